### rtl/tcch_pkg.sv
// shared types and constants of the tilt compensated compass heading block
`timescale 1ns / 1ps
package tcch_pkg;

   typedef struct packed {
      logic signed [15:0] mag_x;
      logic signed [15:0] mag_y;
      logic signed [15:0] mag_z;
      logic signed [15:0] acc_x;
      logic signed [15:0] acc_y;
      logic signed [15:0] acc_z;
   } req_type;

   typedef struct packed {
      logic [15:0] heading_centideg;
      logic        valid_res;
   } rsp_type;

   localparam int SQRT_STEPS   = 32;
   localparam int NORM_STEPS   = 6;
   localparam int CORDIC_STEPS = 30;

   localparam logic [32:0] Q30_PI       = 33'd3373259426;
   localparam logic [32:0] Q30_HALF_PI  = 33'd1686629713;
   localparam logic [32:0] Q30_TWO_PI   = 33'd6746518852;
   localparam logic [30:0] CDEG_MUL     = 31'd1501974482;
   localparam logic [63:0] CDEG_ROUND   = 64'h0000_8000_0000_0000;
   localparam logic [15:0] FULL_TURN    = 16'd36000;

   // atan(2^-i) in q30 radians
   function automatic logic [29:0] atan_entry(input logic [4:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0:  val = 30'd843314857;
         5'd1:  val = 30'd497837829;
         5'd2:  val = 30'd263043837;
         5'd3:  val = 30'd133525159;
         5'd4:  val = 30'd67021687;
         5'd5:  val = 30'd33543516;
         5'd6:  val = 30'd16775851;
         5'd7:  val = 30'd8388437;
         5'd8:  val = 30'd4194283;
         5'd9:  val = 30'd2097149;
         5'd10: val = 30'd1048576;
         5'd11: val = 30'd524288;
         5'd12: val = 30'd262144;
         5'd13: val = 30'd131072;
         5'd14: val = 30'd65536;
         5'd15: val = 30'd32768;
         5'd16: val = 30'd16384;
         5'd17: val = 30'd8192;
         5'd18: val = 30'd4096;
         5'd19: val = 30'd2048;
         5'd20: val = 30'd1024;
         5'd21: val = 30'd512;
         5'd22: val = 30'd256;
         5'd23: val = 30'd128;
         5'd24: val = 30'd64;
         5'd25: val = 30'd32;
         5'd26: val = 30'd16;
         5'd27: val = 30'd8;
         5'd28: val = 30'd4;
         5'd29: val = 30'd2;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

endpackage

### rtl/tilt_compensated_compass_heading.sv
// Tilt compensated compass heading. One magnetometer/accelerometer pair is
// taken per clock while req_ready is high, and each gives one heading, in
// order, on rsp_valid after passing 77 register stages, the first loaded by
// the transfer itself. The stages are four product and cross stages, the
// 32-stage square root of |acc| (one result bit per stage), a scaling multiply
// and six normalizing shift stages, the 30-stage arctangent CORDIC (one
// rotation per stage), three conversion stages and the output register. The
// whole pipeline holds while a two-entry output buffer is full, so a waiting
// result does not stop new transfers until the second entry fills.
`timescale 1ns / 1ps
module tilt_compensated_compass_heading (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcch_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcch_pkg::rsp_type rsp_data
);

   typedef struct packed {
      logic signed [31:0] my_az;
      logic signed [31:0] mz_ay;
      logic signed [31:0] mz_ax;
      logic signed [31:0] mx_az;
      logic signed [31:0] mx_ay;
      logic signed [31:0] my_ax;
      logic [31:0]        ax2;
      logic [31:0]        ay2;
      logic [31:0]        az2;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
   } s1_type;

   typedef struct packed {
      logic signed [32:0] ex;
      logic signed [32:0] ey;
      logic signed [32:0] ez;
      logic               e_zero;
      logic [31:0]        a2;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
   } s2_type;

   typedef struct packed {
      logic signed [48:0] ay_ez;
      logic signed [48:0] az_ey;
      logic signed [48:0] az_ex;
      logic signed [48:0] ax_ez;
      logic signed [48:0] ax_ey;
      logic signed [48:0] ay_ex;
      logic               e_zero;
      logic               ez_neg;
      logic [31:0]        ez_mag;
      logic [31:0]        a2;
   } s3_type;

   typedef struct packed {
      logic [33:0]        rem;
      logic [31:0]        root;
      logic [31:0]        a2;
      logic [31:0]        ez_mag;
      logic signed [49:0] nz;
      logic               ez_neg;
      logic               deg;
   } sq_type;

   typedef struct packed {
      logic [63:0] uy;
      logic [63:0] ux;
      logic        ez_neg;
      logic        nz_neg;
      logic        deg;
   } nm_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic               ez_neg;
      logic               nz_neg;
      logic               deg;
   } cr_type;

   typedef struct packed {
      logic [32:0] ang;
      logic        deg;
   } fa_type;

   typedef struct packed {
      logic [63:0] prod;
      logic        deg;
   } fb_type;

   logic adv;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   logic   s1_vld_ff, s2_vld_ff, s3_vld_ff;

   sq_type sq_ff [0:tcch_pkg::SQRT_STEPS];
   sq_type sq_in [0:tcch_pkg::SQRT_STEPS];
   logic [tcch_pkg::SQRT_STEPS:0] sq_vld_ff;

   nm_type nm_ff [0:tcch_pkg::NORM_STEPS];
   nm_type nm_in [0:tcch_pkg::NORM_STEPS];
   logic [tcch_pkg::NORM_STEPS:0] nm_vld_ff;

   cr_type cr_cur [0:tcch_pkg::CORDIC_STEPS-1];
   cr_type cr_ff  [1:tcch_pkg::CORDIC_STEPS];
   cr_type cr_in  [1:tcch_pkg::CORDIC_STEPS];
   logic [tcch_pkg::CORDIC_STEPS-1:0] cr_vld_cur;
   logic [tcch_pkg::CORDIC_STEPS:1]   cr_vld_ff;

   fa_type fa_ff, fa_in;
   fb_type fb_ff, fb_in;
   tcch_pkg::rsp_type fc_ff, fc_in;
   logic fa_vld_ff, fb_vld_ff, fc_vld_ff;

   tcch_pkg::rsp_type rsp_ff, skid_ff;
   logic rsp_vld_ff, skid_vld_ff;

   assign adv       = ~skid_vld_ff;
   assign req_ready = adv;

   // east products and squares of acc
   always_comb begin
      s1_in.my_az = req_data.mag_y * req_data.acc_z;
      s1_in.mz_ay = req_data.mag_z * req_data.acc_y;
      s1_in.mz_ax = req_data.mag_z * req_data.acc_x;
      s1_in.mx_az = req_data.mag_x * req_data.acc_z;
      s1_in.mx_ay = req_data.mag_x * req_data.acc_y;
      s1_in.my_ax = req_data.mag_y * req_data.acc_x;
      s1_in.ax2   = req_data.acc_x * req_data.acc_x;
      s1_in.ay2   = req_data.acc_y * req_data.acc_y;
      s1_in.az2   = req_data.acc_z * req_data.acc_z;
      s1_in.ax    = req_data.acc_x;
      s1_in.ay    = req_data.acc_y;
      s1_in.az    = req_data.acc_z;
   end

   // east vector
   always_comb begin
      s2_in.ex     = s1_ff.my_az - s1_ff.mz_ay;
      s2_in.ey     = s1_ff.mz_ax - s1_ff.mx_az;
      s2_in.ez     = s1_ff.mx_ay - s1_ff.my_ax;
      s2_in.e_zero = (s1_ff.my_az == s1_ff.mz_ay) && (s1_ff.mz_ax == s1_ff.mx_az)
                     && (s1_ff.mx_ay == s1_ff.my_ax);
      s2_in.a2     = s1_ff.ax2 + s1_ff.ay2 + s1_ff.az2;
      s2_in.ax     = s1_ff.ax;
      s2_in.ay     = s1_ff.ay;
      s2_in.az     = s1_ff.az;
   end

   // north products
   logic signed [32:0] ez_negated;
   always_comb begin
      ez_negated    = -s2_ff.ez;
      s3_in.ay_ez   = s2_ff.ay * s2_ff.ez;
      s3_in.az_ey   = s2_ff.az * s2_ff.ey;
      s3_in.az_ex   = s2_ff.az * s2_ff.ex;
      s3_in.ax_ez   = s2_ff.ax * s2_ff.ez;
      s3_in.ax_ey   = s2_ff.ax * s2_ff.ey;
      s3_in.ay_ex   = s2_ff.ay * s2_ff.ex;
      s3_in.e_zero  = s2_ff.e_zero;
      s3_in.ez_neg  = s2_ff.ez[32];
      s3_in.ez_mag  = s2_ff.ez[32] ? ez_negated[31:0] : s2_ff.ez[31:0];
      s3_in.a2      = s2_ff.a2;
   end

   // north z and degenerate check, square root seed
   always_comb begin
      sq_in[0].rem    = '0;
      sq_in[0].root   = '0;
      sq_in[0].a2     = s3_ff.a2;
      sq_in[0].ez_mag = s3_ff.ez_mag;
      sq_in[0].nz     = 50'(s3_ff.ax_ey) - 50'(s3_ff.ay_ex);
      sq_in[0].ez_neg = s3_ff.ez_neg;
      sq_in[0].deg    = s3_ff.e_zero
                        || ((s3_ff.ay_ez == s3_ff.az_ey) && (s3_ff.az_ex == s3_ff.ax_ez)
                            && (s3_ff.ax_ey == s3_ff.ay_ex));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         sq_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         s1_vld_ff    <= req_valid;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         sq_vld_ff[0] <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         s3_ff    <= s3_in;
         sq_ff[0] <= sq_in[0];
      end
   end

   // square root of a2 << 32, one result bit per stage
   for (genvar j = 0; j < tcch_pkg::SQRT_STEPS; j++) begin : g_sqrt
      logic [1:0]  pair;
      logic [33:0] rem_sh;
      logic [33:0] trial;
      logic        fits;

      if (j < 16) begin : g_hi
         assign pair = sq_ff[j].a2[31-2*j -: 2];
      end else begin : g_lo
         assign pair = 2'b00;
      end

      always_comb begin
         rem_sh = {sq_ff[j].rem[31:0], pair};
         trial  = {sq_ff[j].root, 2'b01};
         fits   = rem_sh >= trial;
         sq_in[j+1]      = sq_ff[j];
         sq_in[j+1].rem  = fits ? rem_sh - trial : rem_sh;
         sq_in[j+1].root = {sq_ff[j].root[30:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[j+1] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[j+1] <= sq_vld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[j+1] <= sq_in[j+1];
         end
      end
   end

   // scaled east and north magnitudes
   logic signed [49:0] nz_negated;
   always_comb begin
      nz_negated      = -sq_ff[tcch_pkg::SQRT_STEPS].nz;
      nm_in[0].uy     = 64'(sq_ff[tcch_pkg::SQRT_STEPS].ez_mag)
                        * 64'(sq_ff[tcch_pkg::SQRT_STEPS].root);
      nm_in[0].ux     = {(sq_ff[tcch_pkg::SQRT_STEPS].nz[49] ? nz_negated[47:0]
                          : sq_ff[tcch_pkg::SQRT_STEPS].nz[47:0]), 16'h0000};
      nm_in[0].ez_neg = sq_ff[tcch_pkg::SQRT_STEPS].ez_neg;
      nm_in[0].nz_neg = sq_ff[tcch_pkg::SQRT_STEPS].nz[49];
      nm_in[0].deg    = sq_ff[tcch_pkg::SQRT_STEPS].deg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         nm_vld_ff[0] <= sq_vld_ff[tcch_pkg::SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nm_ff[0] <= nm_in[0];
      end
   end

   // shift both magnitudes below 2^30, binary search on the shift count
   for (genvar k = 0; k < tcch_pkg::NORM_STEPS; k++) begin : g_norm
      localparam int AMT = 32 >> k;
      logic [63:0] both;
      logic        big;

      always_comb begin
         both = nm_ff[k].uy | nm_ff[k].ux;
         big  = |(both >> (29 + AMT));
         nm_in[k+1]    = nm_ff[k];
         nm_in[k+1].uy = big ? nm_ff[k].uy >> AMT : nm_ff[k].uy;
         nm_in[k+1].ux = big ? nm_ff[k].ux >> AMT : nm_ff[k].ux;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nm_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            nm_vld_ff[k+1] <= nm_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nm_ff[k+1] <= nm_in[k+1];
         end
      end
   end

   always_comb begin
      cr_cur[0].x      = $signed({4'b0000, nm_ff[tcch_pkg::NORM_STEPS].ux[29:0]});
      cr_cur[0].y      = $signed({4'b0000, nm_ff[tcch_pkg::NORM_STEPS].uy[29:0]});
      cr_cur[0].z      = '0;
      cr_cur[0].ez_neg = nm_ff[tcch_pkg::NORM_STEPS].ez_neg;
      cr_cur[0].nz_neg = nm_ff[tcch_pkg::NORM_STEPS].nz_neg;
      cr_cur[0].deg    = nm_ff[tcch_pkg::NORM_STEPS].deg;
      cr_vld_cur[0]    = nm_vld_ff[tcch_pkg::NORM_STEPS];
   end

   // vectoring cordic, one rotation per stage
   for (genvar i = 0; i < tcch_pkg::CORDIC_STEPS; i++) begin : g_cordic
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] da;

      if (i > 0) begin : g_tap
         assign cr_cur[i]     = cr_ff[i];
         assign cr_vld_cur[i] = cr_vld_ff[i];
      end

      always_comb begin
         dx = cr_cur[i].y >>> i;
         dy = cr_cur[i].x >>> i;
         da = $signed({4'b0000, tcch_pkg::atan_entry(5'(i))});
         cr_in[i+1] = cr_cur[i];
         if (cr_cur[i].y > 0) begin
            cr_in[i+1].x = cr_cur[i].x + dx;
            cr_in[i+1].y = cr_cur[i].y - dy;
            cr_in[i+1].z = cr_cur[i].z + da;
         end else begin
            cr_in[i+1].x = cr_cur[i].x - dx;
            cr_in[i+1].y = cr_cur[i].y + dy;
            cr_in[i+1].z = cr_cur[i].z - da;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cr_vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cr_vld_ff[i+1] <= cr_vld_cur[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cr_ff[i+1] <= cr_in[i+1];
         end
      end
   end

   // clamp and place in quadrant
   logic [32:0] t_clamp;
   always_comb begin
      if (cr_ff[tcch_pkg::CORDIC_STEPS].z < 0) begin
         t_clamp = '0;
      end else if (cr_ff[tcch_pkg::CORDIC_STEPS].z > $signed({1'b0, tcch_pkg::Q30_HALF_PI})) begin
         t_clamp = tcch_pkg::Q30_HALF_PI;
      end else begin
         t_clamp = cr_ff[tcch_pkg::CORDIC_STEPS].z[32:0];
      end
      if (!cr_ff[tcch_pkg::CORDIC_STEPS].nz_neg) begin
         fa_in.ang = cr_ff[tcch_pkg::CORDIC_STEPS].ez_neg ? tcch_pkg::Q30_TWO_PI - t_clamp
                     : t_clamp;
      end else begin
         fa_in.ang = cr_ff[tcch_pkg::CORDIC_STEPS].ez_neg ? tcch_pkg::Q30_PI + t_clamp
                     : tcch_pkg::Q30_PI - t_clamp;
      end
      fa_in.deg = cr_ff[tcch_pkg::CORDIC_STEPS].deg;
   end

   // radians to hundredths of a degree
   always_comb begin
      fb_in.prod = 64'(fa_ff.ang) * 64'(tcch_pkg::CDEG_MUL);
      fb_in.deg  = fa_ff.deg;
   end

   logic [63:0] rounded;
   always_comb begin
      rounded = fb_ff.prod + tcch_pkg::CDEG_ROUND;
      if (fb_ff.deg || rounded[63:48] >= tcch_pkg::FULL_TURN) begin
         fc_in.heading_centideg = '0;
      end else begin
         fc_in.heading_centideg = rounded[63:48];
      end
      fc_in.valid_res = ~fb_ff.deg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fa_vld_ff <= 1'b0;
         fb_vld_ff <= 1'b0;
         fc_vld_ff <= 1'b0;
      end else if (adv) begin
         fa_vld_ff <= cr_vld_ff[tcch_pkg::CORDIC_STEPS];
         fb_vld_ff <= fa_vld_ff;
         fc_vld_ff <= fb_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fa_ff <= fa_in;
         fb_ff <= fb_in;
         fc_ff <= fc_in;
      end
   end

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!rsp_vld_ff || rsp_ready) begin
         if (skid_vld_ff) begin
            rsp_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            rsp_vld_ff <= fc_vld_ff;
         end
      end else if (fc_vld_ff && adv) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_vld_ff || rsp_ready) begin
         rsp_ff <= skid_vld_ff ? skid_ff : fc_ff;
      end else if (adv) begin
         skid_ff <= fc_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid entry full while output register empty");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_ff.heading_centideg < tcch_pkg::FULL_TURN))
      else $error("heading out of range");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ff.valid_res) |-> (rsp_ff.heading_centideg == 16'd0))
      else $error("degenerate result with nonzero heading");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (!adv && fc_vld_ff) |=> fc_vld_ff)
      else $error("pipeline result lost during stall");

endmodule
